// ===== design/hcbp_pkg.sv =====
// shared types, opcodes and helpers of the huffman code bit packer
package hcbp_pkg;

  localparam int SYMBOLS_DEF      = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int WIN_W  = 40;   // 7 pending bits plus a full code, rounded to bytes
  localparam int AMT_W  = 6;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_ENCODE   = 2'd1;
  localparam logic [1:0] OP_FLUSH    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] pad_bits;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // keep only the low len bits of a code
  function automatic logic [CODE_W-1:0] code_mask(input logic [CODE_W-1:0] code,
                                                  input logic [LEN_W-1:0]  len);
    logic [CODE_W-1:0] m;
    if (len >= LEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return code & m;
  endfunction

endpackage

// ===== design/hcbp_ram.sv =====
// generic single-write, single-read ram with registered read data
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/hcbp_shift.sv =====
// shared left shifter over the bit window, used for alignment and byte advance
module hcbp_shift (
  input  logic [hcbp_pkg::WIN_W-1:0] shift_in,
  input  logic [hcbp_pkg::AMT_W-1:0] shift_amt,
  output logic [hcbp_pkg::WIN_W-1:0] shift_out
);

  assign shift_out = shift_in << shift_amt;

endmodule

// ===== design/huffman_code_bit_packer.sv =====
// top level of the huffman code bit packer: code table, sequencer and output register
//
//  channel | ports                        | beat carries
//  --------+------------------------------+---------------------------------------
//  input   | in_valid, in_stall, in_data  | opcode, symbol, code_bits, code_length
//  output  | out_valid, out_stall, out_data | out_byte, pad_bits, last
//
// a load writes the table and stays idle; an encode that yields n bytes (0..4) reads
// its entry, then emits one byte per cycle while the output register is free, through the
// single 40-bit window shifter; a zero-length encode ends after the read; a flush emits
// the padded byte; an idle flush, an out-of-table encode or an unknown opcode stays idle.
// reset clears the table valid bits and the pending bits at once, no clearing pass.
// out_stall holds the output register and with it the byte sequencer.
module huffman_code_bit_packer #(
  parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcbp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hcbp_pkg::out_t out_data
);

  localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CAP   = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
  localparam int ENT_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;
  localparam int WIN_W = hcbp_pkg::WIN_W;

  hcbp_pkg::state_t state_r, state_nxt;

  logic [SYMBOLS-1:0]        vld_r, vld_nxt;
  logic                      vld_q_r;
  logic [6:0]                pl_r, pl_nxt;
  logic [2:0]                pc_r, pc_nxt;
  logic [WIN_W-1:0]          w_r, w_nxt;
  logic [5:0]                total_r, total_nxt;
  logic                      out_valid_r, out_valid_nxt;
  hcbp_pkg::out_t            out_r, out_nxt;

  logic                      accept;
  logic                      in_range;
  logic [IDX_W-1:0]          sym_idx;
  logic [hcbp_pkg::LEN_W-1:0] len_sat;
  logic                      wr_en;
  logic [ENT_W-1:0]          wr_data;
  logic                      rd_en;
  logic [ENT_W-1:0]          rd_data;
  logic [hcbp_pkg::LEN_W-1:0] len_eff;
  logic [5:0]                total_new;
  logic                      slot_free;
  logic                      load_out;
  logic [WIN_W-1:0]          shift_in;
  logic [hcbp_pkg::AMT_W-1:0] shift_amt;
  logic [WIN_W-1:0]          shift_out;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != hcbp_pkg::ST_IDLE);
  assign sym_idx   = in_data.symbol[IDX_W-1:0];
  assign in_range  = ({1'b0, in_data.symbol} < 9'(SYMBOLS));
  assign slot_free = !out_valid_r || !out_stall;

  assign len_sat = (in_data.code_length > hcbp_pkg::LEN_W'(CAP)) ?
                   hcbp_pkg::LEN_W'(CAP) : in_data.code_length;

  assign wr_en   = accept && in_range && (in_data.opcode == hcbp_pkg::OP_LOAD);
  assign wr_data = {len_sat, hcbp_pkg::code_mask(in_data.code_bits, len_sat)};
  assign rd_en   = accept && in_range && (in_data.opcode == hcbp_pkg::OP_ENCODE);

  hcbp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SYMBOLS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(sym_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(sym_idx),
    .rd_data(rd_data)
  );

  // an entry never loaded reads as length zero
  assign len_eff   = vld_q_r ? rd_data[ENT_W-1 -: hcbp_pkg::LEN_W] : '0;
  assign total_new = 6'({3'b000, pc_r}) + len_eff;

  hcbp_shift u_shift (
    .shift_in (shift_in),
    .shift_amt(shift_amt),
    .shift_out(shift_out)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (accept && in_range && (in_data.opcode == hcbp_pkg::OP_ENCODE)) begin
          state_nxt = hcbp_pkg::ST_READ;
        end else if (accept && (in_data.opcode == hcbp_pkg::OP_FLUSH) && (pc_r != 3'd0)) begin
          state_nxt = hcbp_pkg::ST_FLUSH;
        end
      end
      hcbp_pkg::ST_READ: begin
        state_nxt = (len_eff == '0) ? hcbp_pkg::ST_IDLE : hcbp_pkg::ST_EMIT;
      end
      hcbp_pkg::ST_EMIT: begin
        if (total_r < 6'd8) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (slot_free) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hcbp_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    vld_nxt   = vld_r;
    pl_nxt    = pl_r;
    pc_nxt    = pc_r;
    w_nxt     = w_r;
    total_nxt = total_r;
    load_out  = 1'b0;
    out_nxt   = out_r;
    shift_in  = w_r;
    shift_amt = hcbp_pkg::AMT_W'(8);
    if (wr_en) begin
      vld_nxt[sym_idx] = 1'b1;
    end
    unique case (state_r)
      hcbp_pkg::ST_IDLE: begin
      end
      hcbp_pkg::ST_READ: begin
        // place the code right behind the pending bits, left-aligned in the window
        shift_in  = {8'h00, rd_data[hcbp_pkg::CODE_W-1:0]};
        shift_amt = hcbp_pkg::AMT_W'(6'd40 - total_new);
        w_nxt     = shift_out | {pl_r, 33'd0};
        total_nxt = total_new;
      end
      hcbp_pkg::ST_EMIT: begin
        if (total_r < 6'd8) begin
          pl_nxt = w_r[WIN_W-1 -: 7];
          pc_nxt = total_r[2:0];
        end else if (slot_free) begin
          load_out         = 1'b1;
          out_nxt.out_byte = w_r[WIN_W-1 -: 8];
          out_nxt.pad_bits = 3'd0;
          out_nxt.last     = (total_r < 6'd16);
          w_nxt            = shift_out;
          total_nxt        = total_r - 6'd8;
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (slot_free) begin
          load_out         = 1'b1;
          out_nxt.out_byte = {pl_r, 1'b0};
          out_nxt.pad_bits = 3'd0 - pc_r;
          out_nxt.last     = 1'b1;
          pl_nxt           = '0;
          pc_nxt           = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcbp_pkg::ST_IDLE;
      vld_r       <= '0;
      pl_r        <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      pl_r        <= pl_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q_r <= vld_r[sym_idx];
    end
    w_r     <= w_nxt;
    total_r <= total_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // unused pending positions must stay zero so a flush pads with zeros
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == 3'd0) |-> (pl_r == 7'd0))
    else $error("pending bits set with zero pending count");

  a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.pad_bits != 3'd0)) |-> out_r.last)
    else $error("padded byte not marked last");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcbp_pkg::ST_FLUSH && slot_free) |=> (pc_r == 3'd0))
    else $error("flush left pending bits");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcbp_pkg::ST_EMIT) |-> (total_r <= 6'd39))
    else $error("bit window overfilled");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == hcbp_pkg::ST_EMIT ||
                            $past(state_r) == hcbp_pkg::ST_FLUSH))
    else $error("output beat raised outside emit or flush");

endmodule
